FILE: rtl/tccs_pkg.sv
// ----------------------------------------------------------------------------
// tccs_pkg
// Shared constants, command and result types for the text console engine.
// ----------------------------------------------------------------------------
package tccs_pkg;

	// screen geometry
	localparam int COLUMNS   = 80;
	localparam int ROWS      = 25;
	localparam int TAB_WIDTH = 4;
	localparam int CELLS     = COLUMNS * ROWS;

	// derived widths
	localparam int ADDR_W = $clog2(CELLS);
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS + 1);

	// port field widths
	localparam int OP_W   = 2;
	localparam int CHAR_W = 8;
	localparam int ATTR_W = 8;
	localparam int POS_W  = 11;

	// character codes
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
	localparam logic [CHAR_W-1:0] CH_NUL   = 8'd0;

	// fill colour after reset: black background, light grey text
	localparam logic [ATTR_W-1:0] FILL_RESET = 8'h07;

	// first cell of the bottom row
	localparam int LAST_ROW = CELLS - COLUMNS;

	// operation codes on the op port
	typedef enum logic [OP_W-1:0] {
		OP_PUT   = 2'd0,
		OP_CLEAR = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	// classified command kinds
	typedef enum logic [2:0] {
		K_CHAR,
		K_LF,
		K_CR,
		K_TAB,
		K_CLEAR,
		K_READ,
		K_NOP
	} kind_t;

	// command from the front end to the engine
	typedef struct packed {
		kind_t              kind;
		logic [CHAR_W-1:0]  ch;
		logic [ADDR_W-1:0]  addr;
		logic               addr_ok;
	} cmd_t;

	// result item
	typedef struct packed {
		logic [POS_W-1:0]   cursor_pos;
		logic [CHAR_W-1:0]  cell_char;
		logic [ATTR_W-1:0]  cell_colour;
	} res_t;

	// engine sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_CHECK,
		ST_SCROLL,
		ST_FILL,
		ST_CLEAR,
		ST_RDWAIT,
		ST_RESULT
	} state_t;

endpackage

FILE: rtl/tccs_front.sv
// ----------------------------------------------------------------------------
// tccs_front
// Accepts input items, classifies them into commands and holds them in a
// two-entry command queue in front of the engine.
// ----------------------------------------------------------------------------
module tccs_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [tccs_pkg::OP_W-1:0]     op,
	input  logic [tccs_pkg::CHAR_W-1:0]   char_code,
	input  logic [tccs_pkg::POS_W-1:0]    cell_index,
	output tccs_pkg::cmd_t                cmd,
	output logic                          cmd_valid,
	input  logic                          cmd_pop
);
	import tccs_pkg::*;

	cmd_t       cls;
	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	// classify the incoming item
	always_comb begin
		cls.ch      = char_code;
		cls.addr_ok = (cell_index < POS_W'(CELLS));
		cls.addr    = cls.addr_ok ? ADDR_W'(cell_index) : '0;
		unique case (op)
			OP_PUT: begin
				priority if (char_code == CH_LF)  cls.kind = K_LF;
				else if (char_code == CH_CR)      cls.kind = K_CR;
				else if (char_code == CH_TAB)     cls.kind = K_TAB;
				else                              cls.kind = K_CHAR;
			end
			OP_CLEAR: cls.kind = K_CLEAR;
			OP_READ:  cls.kind = K_READ;
			default:  cls.kind = K_NOP;
		endcase
	end

	// queue handshake
	assign full      = (count_q == 2'd2);
	assign cmd_valid = (count_q != 2'd0);
	assign do_push   = push && !full;
	assign do_pop    = cmd_pop && cmd_valid;
	assign cmd       = slot_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= cls;
		end
	end

	// queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

FILE: rtl/tccs_resq.sv
// ----------------------------------------------------------------------------
// tccs_resq
// Two-entry result queue between the engine and the result port.
// ----------------------------------------------------------------------------
module tccs_resq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           res_push,
	output logic           res_full,
	input  tccs_pkg::res_t res_in,
	output logic           empty,
	input  logic           pop,
	output tccs_pkg::res_t res_out
);
	import tccs_pkg::*;

	res_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	// handshake
	assign res_full = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign do_push  = res_push && !res_full;
	assign do_pop   = pop && !empty;
	assign res_out  = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= res_in;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

FILE: rtl/tccs_engine.sv
// ----------------------------------------------------------------------------
// tccs_engine
// Carries out console commands against the cell store: character writes,
// tab fill, scroll copy, clear sweep and cell reads, and keeps the cursor.
// ----------------------------------------------------------------------------
module tccs_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tccs_pkg::ATTR_W-1:0]   cfg_wdata,
	input  tccs_pkg::cmd_t                cmd,
	input  logic                          cmd_valid,
	output logic                          cmd_pop,
	output tccs_pkg::res_t                res,
	output logic                          res_push,
	input  logic                          res_full
);
	import tccs_pkg::*;

	// cell store, character and attribute planes
	logic [CHAR_W-1:0] char_mem [CELLS];
	logic [ATTR_W-1:0] attr_mem [CELLS];
	logic [CHAR_W-1:0] rd_char_q;
	logic [ATTR_W-1:0] rd_attr_q;

	state_t            state_q;
	state_t            state_d;
	cmd_t              cmd_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [ATTR_W-1:0] fill_q;
	logic [ADDR_W-1:0] cnt_q;
	logic [ADDR_W-1:0] wr_addr_q;
	logic              pend_q;
	logic [CHAR_W-1:0] rc_q;
	logic [ATTR_W-1:0] rcol_q;

	logic [COL_W:0]    col_inc;
	logic              tab_stop;
	logic              at_bottom;
	logic [ADDR_W-1:0] cur_addr;
	logic              we_char;
	logic              we_attr;
	logic [ADDR_W-1:0] waddr;
	logic [CHAR_W-1:0] wchar;
	logic [ATTR_W-1:0] wattr;
	logic [ADDR_W-1:0] raddr;

	// cursor arithmetic
	assign col_inc   = {1'b0, col_q} + 1'b1;
	assign tab_stop  = ((col_inc % TAB_WIDTH) == 0) || (col_inc >= (COL_W + 1)'(COLUMNS));
	assign at_bottom = (row_q == ROW_W'(ROWS));
	assign cur_addr  = ADDR_W'(int'(row_q) * COLUMNS + int'(col_q));

	// result item
	assign res.cursor_pos  = POS_W'(int'(row_q) * COLUMNS + int'(col_q));
	assign res.cell_char   = rc_q;
	assign res.cell_colour = rcol_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid && !res_full) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				unique case (cmd_q.kind)
					K_CHAR:  state_d = ST_CHECK;
					K_LF:    state_d = ST_CHECK;
					K_TAB:   state_d = tab_stop ? ST_CHECK : ST_EXEC;
					K_CLEAR: state_d = ST_CLEAR;
					K_READ:  state_d = ST_RDWAIT;
					default: state_d = ST_RESULT;
				endcase
			end
			ST_CHECK:  state_d = at_bottom ? ST_SCROLL : ST_RESULT;
			ST_SCROLL: begin
				if (cnt_q == ADDR_W'(LAST_ROW)) begin
					state_d = ST_FILL;
				end
			end
			ST_FILL, ST_CLEAR: begin
				if (cnt_q == ADDR_W'(CELLS - 1)) begin
					state_d = ST_RESULT;
				end
			end
			ST_RDWAIT: state_d = ST_RESULT;
			ST_RESULT: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// store and handshake controls
	always_comb begin
		cmd_pop  = 1'b0;
		res_push = 1'b0;
		we_char  = 1'b0;
		we_attr  = 1'b0;
		waddr    = cur_addr;
		wchar    = cmd_q.ch;
		wattr    = fill_q;
		raddr    = '0;
		unique case (state_q)
			ST_IDLE: cmd_pop = cmd_valid && !res_full;
			ST_EXEC: begin
				unique case (cmd_q.kind)
					K_CHAR: we_char = 1'b1;
					K_TAB: begin
						we_char = 1'b1;
						wchar   = CH_SPACE;
					end
					K_READ:  raddr = cmd_q.addr;
					default: ;
				endcase
			end
			ST_SCROLL: begin
				// read one row ahead, write the previous read back one row up
				if (cnt_q != ADDR_W'(LAST_ROW)) begin
					raddr = cnt_q + ADDR_W'(COLUMNS);
				end
				we_char = pend_q;
				we_attr = pend_q;
				waddr   = wr_addr_q;
				wchar   = rd_char_q;
				wattr   = rd_attr_q;
			end
			ST_FILL: begin
				we_char = 1'b1;
				we_attr = 1'b1;
				waddr   = cnt_q;
				wchar   = CH_NUL;
			end
			ST_CLEAR: begin
				we_char = 1'b1;
				we_attr = 1'b1;
				waddr   = cnt_q;
				wchar   = CH_SPACE;
			end
			ST_RESULT: res_push = 1'b1;
			default: ;
		endcase
	end

	// cell store ports
	always_ff @(posedge clk) begin
		if (we_char) begin
			char_mem[waddr] <= wchar;
		end
		if (we_attr) begin
			attr_mem[waddr] <= wattr;
		end
		rd_char_q <= char_mem[raddr];
		rd_attr_q <= attr_mem[raddr];
	end

	// command and read data capture
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q  <= cmd;
			rc_q   <= '0;
			rcol_q <= '0;
		end else if (state_q == ST_RDWAIT && cmd_q.addr_ok) begin
			rc_q   <= rd_char_q;
			rcol_q <= rd_attr_q;
		end
	end

	// sequencer, cursor and sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			col_q     <= '0;
			row_q     <= '0;
			fill_q    <= FILL_RESET;
			cnt_q     <= '0;
			wr_addr_q <= '0;
			pend_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				fill_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_EXEC: begin
					unique case (cmd_q.kind)
						K_CHAR, K_TAB: begin
							if (col_inc >= (COL_W + 1)'(COLUMNS)) begin
								col_q <= '0;
								row_q <= row_q + 1'b1;
							end else begin
								col_q <= col_inc[COL_W-1:0];
							end
						end
						K_LF: begin
							col_q <= '0;
							row_q <= row_q + 1'b1;
						end
						K_CR:    col_q <= '0;
						K_CLEAR: cnt_q <= '0;
						default: ;
					endcase
				end
				ST_CHECK: begin
					pend_q <= 1'b0;
					cnt_q  <= '0;
					if (at_bottom) begin
						row_q <= ROW_W'(ROWS - 1);
					end
				end
				ST_SCROLL: begin
					if (cnt_q != ADDR_W'(LAST_ROW)) begin
						wr_addr_q <= cnt_q;
						pend_q    <= 1'b1;
						cnt_q     <= cnt_q + 1'b1;
					end else begin
						pend_q <= 1'b0;
					end
				end
				ST_FILL: cnt_q <= cnt_q + 1'b1;
				ST_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ADDR_W'(CELLS - 1)) begin
						col_q <= '0;
						row_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// cursor stays on screen whenever a result goes out
	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (row_q < ROW_W'(ROWS)))
		else $error("cursor row off screen at result");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q < COL_W'(COLUMNS))
		else $error("cursor column out of range");

	// a command is only taken when its result has room
	a_pop_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> (cmd_valid && !res_full))
		else $error("command taken without result space");

	// one command in, exactly one result out before the next
	a_push_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (!cmd_pop && !res_full))
		else $error("result pushed while full or overlapping a command fetch");

	// scroll fill runs with the cursor already on the bottom row
	a_fill_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL) |-> (row_q == ROW_W'(ROWS - 1)))
		else $error("scroll fill with cursor not on bottom row");

endmodule

FILE: rtl/text_console_cursor_scroll.sv
// ----------------------------------------------------------------------------
// text_console_cursor_scroll
// Text console engine over an 80x25 cell store with cursor, tab, scroll
// and clear.
// ----------------------------------------------------------------------------
// Items enter through a queue-style port (push/full) and results leave the
// same way (empty/pop), one result per item, in order. A front end classifies
// each item into a two-entry command queue; the engine works one command at a
// time against a single-write, single-read cell store. A tab writes spaces up
// to the next tab stop, at most TAB_WIDTH of them. A put that runs past the
// bottom row adds a scroll: the store copies one cell per cycle through its
// one write port, then fills the bottom row with NUL in the fill colour. The
// store has no reset and no clearing pass: a cell read before it was written,
// by a clear or otherwise, returns undefined data. fill_colour (reset 8'h07)
// is written through cfg_we/cfg_wdata; the user must write it only while the
// block is idle, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [tccs_pkg::OP_W-1:0]     op,
	input  logic [tccs_pkg::CHAR_W-1:0]   char_code,
	input  logic [tccs_pkg::POS_W-1:0]    cell_index,
	output logic                          empty,
	input  logic                          pop,
	output logic [tccs_pkg::POS_W-1:0]    cursor_pos,
	output logic [tccs_pkg::CHAR_W-1:0]   cell_char,
	output logic [tccs_pkg::ATTR_W-1:0]   cell_colour,
	input  logic                          cfg_we,
	input  logic [tccs_pkg::ATTR_W-1:0]   cfg_wdata
);
	import tccs_pkg::*;

	cmd_t cmd;
	logic cmd_valid;
	logic cmd_pop;
	res_t res_eng;
	res_t res_out;
	logic res_push;
	logic res_full;

	// item intake and command queue
	tccs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.op         (op),
		.char_code  (char_code),
		.cell_index (cell_index),
		.cmd        (cmd),
		.cmd_valid  (cmd_valid),
		.cmd_pop    (cmd_pop)
	);

	// command execution and cell store
	tccs_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.res       (res_eng),
		.res_push  (res_push),
		.res_full  (res_full)
	);

	// result queue
	tccs_resq u_resq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res_full (res_full),
		.res_in   (res_eng),
		.empty    (empty),
		.pop      (pop),
		.res_out  (res_out)
	);

	// result fields
	assign cursor_pos  = res_out.cursor_pos;
	assign cell_char   = res_out.cell_char;
	assign cell_colour = res_out.cell_colour;

endmodule

FILE: verif/tb_text_console_cursor_scroll.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_console_cursor_scroll
// Self-checking bench for the text console engine.
// ----------------------------------------------------------------------------
// A short scripted run covers the corner cases. These are reads at both ends
// of the cell store and past it, a put before the first clear, the unused op,
// tab, return and newline, a NUL character, and clears under two fill colours.
// Randomized text lines, newline bursts and reads follow. They drive the cursor
// through line wrap, tab wrap at the line end and scroll, under several fill
// colours. A behavioral copy of the console inside the bench predicts each
// result, unless a script row gives its own, and each transfer is checked.
// Both sides idle in random bursts. The result side holds off once for long
// enough to back the engine up to its input.
// ----------------------------------------------------------------------------
module tb_text_console_cursor_scroll;
	import tccs_pkg::*;

	localparam logic [OP_W-1:0] OP_NONE = 2'd3;
	// worst case: every item scrolls or clears, plus both stalls
	localparam int CYCLE_LIMIT = 10_000_000;
	localparam int HOLD_CYCLES = 600;
	localparam int PHASE_ITEMS = 190;
	localparam int MAX_PRINTS  = 40;

	typedef enum logic {ROW_ITEM, ROW_FILL} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		logic [OP_W-1:0]    op;
		logic [CHAR_W-1:0]  ch;
		logic [POS_W-1:0]   idx;
		bit                 typed;
		res_t               want;
	} script_row_t;

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 push       = 1'b0;
	logic                 full;
	logic [OP_W-1:0]      op         = OP_PUT;
	logic [CHAR_W-1:0]    char_code  = '0;
	logic [POS_W-1:0]     cell_index = '0;
	logic                 empty;
	logic                 pop        = 1'b0;
	logic [POS_W-1:0]     cursor_pos;
	logic [CHAR_W-1:0]    cell_char;
	logic [ATTR_W-1:0]    cell_colour;
	logic                 cfg_we     = 1'b0;
	logic [ATTR_W-1:0]    cfg_wdata  = '0;

	// console copy: cells are {colour, char}
	logic [ATTR_W+CHAR_W-1:0] screen [CELLS];
	logic [COL_W-1:0]         cur_col   = '0;
	logic [ROW_W-1:0]         cur_row   = '0;
	logic [ATTR_W-1:0]        fill_attr = FILL_RESET;

	res_t        answers_due [$];
	script_row_t script [$];
	int          items_sent    = 0;
	int          fail_count    = 0;
	int          cycle_count   = 0;
	int          send_idle_pct = 20;
	int          recv_idle_pct = 20;
	bit          hold_req      = 1'b0;

	text_console_cursor_scroll u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.op          (op),
		.char_code   (char_code),
		.cell_index  (cell_index),
		.empty       (empty),
		.pop         (pop),
		.cursor_pos  (cursor_pos),
		.cell_char   (cell_char),
		.cell_colour (cell_colour),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// run guard
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("[text_console_cursor_scroll] ERROR");
		$finish;
	end

	task automatic report_mismatch(input string what);
		if (fail_count < MAX_PRINTS)
			$display("mismatch at %0t: %s", $time, what);
		fail_count++;
	endtask

	// apply one item to the console copy and work out its result
	task automatic console_apply(input logic [OP_W-1:0] op_v, input logic [CHAR_W-1:0] ch_v,
			input logic [POS_W-1:0] idx_v, output res_t res);
		int i;
		int cell_idx;
		res = '0;
		case (op_v)
			OP_PUT: begin
				case (ch_v)
					CH_LF: begin
						cur_col = '0;
						cur_row++;
					end
					CH_CR: begin
						cur_col = '0;
					end
					CH_TAB: begin
						// spaces up to the next tab stop, colours kept
						do begin
							cell_idx = cur_row * COLUMNS + cur_col;
							screen[cell_idx][CHAR_W-1:0] = CH_SPACE;
							cur_col++;
						end while ((cur_col % TAB_WIDTH) != 0 && cur_col < COLUMNS);
						if (cur_col >= COLUMNS) begin
							cur_col = '0;
							cur_row++;
						end
					end
					default: begin
						cell_idx = cur_row * COLUMNS + cur_col;
						screen[cell_idx][CHAR_W-1:0] = ch_v;
						if (cur_col == COLUMNS - 1) begin
							cur_col = '0;
							cur_row++;
						end else begin
							cur_col++;
						end
					end
				endcase
				// past the bottom: scroll up one row, NUL fill
				if (cur_row >= ROWS) begin
					for (i = 0; i < LAST_ROW; i++)
						screen[i] = screen[i + COLUMNS];
					for (i = LAST_ROW; i < CELLS; i++)
						screen[i] = {fill_attr, CH_NUL};
					cur_row--;
				end
			end
			OP_CLEAR: begin
				for (i = 0; i < CELLS; i++)
					screen[i] = {fill_attr, CH_SPACE};
				cur_col = '0;
				cur_row = '0;
			end
			OP_READ: begin
				if (idx_v < CELLS) begin
					res.cell_char   = screen[idx_v][CHAR_W-1:0];
					res.cell_colour = screen[idx_v][ATTR_W+CHAR_W-1:CHAR_W];
				end
			end
			default: begin
			end
		endcase
		res.cursor_pos = POS_W'(cur_row * COLUMNS + cur_col);
	endtask

	// offer one item until the transfer happens
	task automatic send_item(input logic [OP_W-1:0] op_v, input logic [CHAR_W-1:0] ch_v,
			input logic [POS_W-1:0] idx_v, input bit typed, input res_t want);
		int gap;
		res_t predicted;
		gap = 0;
		if ($urandom_range(0, 99) < send_idle_pct)
			gap = $urandom_range(1, 18);
		@(negedge clk);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push       <= 1'b1;
		op         <= op_v;
		char_code  <= ch_v;
		cell_index <= idx_v;
		@(posedge clk);
		while (full)
			@(posedge clk);
		console_apply(op_v, ch_v, idx_v, predicted);
		answers_due.push_back(typed ? want : predicted);
		items_sent++;
	endtask

	// register write once the engine has drained
	task automatic write_fill(input logic [ATTR_W-1:0] value);
		@(negedge clk);
		push <= 1'b0;
		while (answers_due.size() != 0)
			@(posedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		fill_attr = value;
	endtask

	// mostly in range, some past the last cell
	task automatic random_read();
		logic [POS_W-1:0] idx_v;
		if ($urandom_range(0, 99) < 10)
			idx_v = POS_W'($urandom_range(CELLS, (1 << POS_W) - 1));
		else
			idx_v = POS_W'($urandom_range(0, CELLS - 1));
		send_item(OP_READ, CHAR_W'($urandom), idx_v, 1'b0, '0);
	endtask

	// one random sequence: mostly text lines, with bursts and odd items
	task automatic random_sequence();
		int pick;
		int len;
		int i;
		logic [CHAR_W-1:0] ch_v;
		pick = $urandom_range(0, 99);
		if (pick < 3) begin
			send_item(OP_CLEAR, CHAR_W'($urandom), POS_W'($urandom), 1'b0, '0);
		end else if (pick < 13) begin
			repeat ($urandom_range(5, 30))
				send_item(OP_PUT, CH_LF, POS_W'($urandom), 1'b0, '0);
		end else if (pick < 20) begin
			repeat ($urandom_range(1, 6))
				random_read();
		end else if (pick < 22) begin
			send_item(OP_NONE, CHAR_W'($urandom), POS_W'($urandom), 1'b0, '0);
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 50)
				len = $urandom_range(0, 8);
			else if (pick < 80)
				len = $urandom_range(9, 40);
			else
				len = $urandom_range(60, 100);
			for (i = 0; i < len; i++) begin
				if ($urandom_range(0, 99) < 10) begin
					random_read();
				end else begin
					if ($urandom_range(0, 99) < 85)
						ch_v = CHAR_W'($urandom_range(32, 126));
					else
						ch_v = CHAR_W'($urandom_range(0, 255));
					send_item(OP_PUT, ch_v, POS_W'($urandom), 1'b0, '0);
				end
			end
			// line ending
			pick = $urandom_range(0, 99);
			if (pick < 55)
				send_item(OP_PUT, CH_LF, POS_W'($urandom), 1'b0, '0);
			else if (pick < 70)
				send_item(OP_PUT, CH_TAB, POS_W'($urandom), 1'b0, '0);
			else if (pick < 80)
				send_item(OP_PUT, CH_CR, POS_W'($urandom), 1'b0, '0);
		end
	endtask

	function automatic void add_row(input row_kind_t kind, input logic [OP_W-1:0] op_v,
			input logic [CHAR_W-1:0] ch_v, input logic [POS_W-1:0] idx_v, input bit typed,
			input logic [POS_W-1:0] pos, input logic [CHAR_W-1:0] c,
			input logic [ATTR_W-1:0] a);
		script_row_t r;
		r.kind  = kind;
		r.op    = op_v;
		r.ch    = ch_v;
		r.idx   = idx_v;
		r.typed = typed;
		r.want  = '{cursor_pos: pos, cell_char: c, cell_colour: a};
		script.push_back(r);
	endfunction

	// result side: random stalls, one long hold on request
	initial begin : result_drain
		int stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				stall_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (stall_left > 0) begin
				pop <= 1'b0;
				stall_left--;
			end else begin
				pop <= 1'b1;
				if ($urandom_range(0, 99) < recv_idle_pct)
					stall_left = $urandom_range(1, 18);
			end
		end
	end

	// check each result transfer against the oldest expected result
	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && pop && !empty) begin
			if (answers_due.size() == 0) begin
				report_mismatch($sformatf("transfer with nothing expected, cursor_pos %0d",
					cursor_pos));
			end else begin
				want = answers_due.pop_front();
				if (cursor_pos !== want.cursor_pos)
					report_mismatch($sformatf("cursor_pos %0d, expected %0d",
						cursor_pos, want.cursor_pos));
				if (cell_char !== want.cell_char)
					report_mismatch($sformatf("cell_char %0h, expected %0h",
						cell_char, want.cell_char));
				if (cell_colour !== want.cell_colour)
					report_mismatch($sformatf("cell_colour %0h, expected %0h",
						cell_colour, want.cell_colour));
			end
		end
	end

	initial begin : stimulus
		script_row_t r;
		logic [ATTR_W-1:0] fill_next;
		int ph;
		int target;

		//       kind      op         char      index     typed pos  char      colour
		add_row(ROW_ITEM, OP_PUT,   8'h41,    11'd0,    1'b1, 1,   8'h00,    8'h00);
		add_row(ROW_ITEM, OP_NONE,  8'hFF,    11'd2047, 1'b1, 1,   8'h00,    8'h00);
		add_row(ROW_FILL, OP_PUT,   8'h1E,    11'd0,    1'b0, 0,   8'h00,    8'h00);
		add_row(ROW_ITEM, OP_CLEAR, 8'h00,    11'd0,    1'b1, 0,   8'h00,    8'h00);
		add_row(ROW_ITEM, OP_READ,  8'h00,    11'd0,    1'b1, 0,   CH_SPACE, 8'h1E);
		add_row(ROW_ITEM, OP_READ,  8'h00,    11'd1999, 1'b1, 0,   CH_SPACE, 8'h1E);
		add_row(ROW_ITEM, OP_READ,  8'h00,    11'd2000, 1'b1, 0,   8'h00,    8'h00);
		add_row(ROW_ITEM, OP_READ,  8'hFF,    11'd2047, 1'b1, 0,   8'h00,    8'h00);
		add_row(ROW_ITEM, OP_PUT,   8'hFF,    11'd0,    1'b1, 1,   8'h00,    8'h00);
		add_row(ROW_ITEM, OP_READ,  8'h00,    11'd0,    1'b1, 1,   8'hFF,    8'h1E);
		add_row(ROW_ITEM, OP_PUT,   CH_TAB,   11'd0,    1'b0, 0,   8'h00,    8'h00);
		add_row(ROW_ITEM, OP_READ,  8'h00,    11'd2,    1'b0, 0,   8'h00,    8'h00);
		add_row(ROW_ITEM, OP_PUT,   CH_CR,    11'd0,    1'b1, 0,   8'h00,    8'h00);
		add_row(ROW_ITEM, OP_PUT,   CH_TAB,   11'd0,    1'b0, 0,   8'h00,    8'h00);
		add_row(ROW_ITEM, OP_PUT,   CH_LF,    11'd0,    1'b1, 80,  8'h00,    8'h00);
		add_row(ROW_ITEM, OP_PUT,   CH_NUL,   11'd0,    1'b1, 81,  8'h00,    8'h00);
		add_row(ROW_ITEM, OP_READ,  8'h00,    11'd80,   1'b1, 81,  CH_NUL,   8'h1E);
		add_row(ROW_ITEM, OP_PUT,   8'h7F,    11'd0,    1'b0, 0,   8'h00,    8'h00);
		add_row(ROW_FILL, OP_PUT,   8'hE1,    11'd0,    1'b0, 0,   8'h00,    8'h00);
		add_row(ROW_ITEM, OP_CLEAR, 8'h00,    11'd0,    1'b1, 0,   8'h00,    8'h00);
		add_row(ROW_ITEM, OP_READ,  8'h00,    11'd1000, 1'b1, 0,   CH_SPACE, 8'hE1);
		add_row(ROW_ITEM, OP_NONE,  8'h00,    11'd0,    1'b1, 0,   8'h00,    8'h00);

		// reset
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// scripted corner cases
		foreach (script[i]) begin
			r = script[i];
			if (r.kind == ROW_FILL)
				write_fill(r.ch);
			else
				send_item(r.op, r.ch, r.idx, r.typed, r.want);
		end

		// random phases, each under its own fill colour and idle mix
		for (ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin
					fill_next = 8'hFF;
					send_idle_pct = 25;
					recv_idle_pct = 25;
				end
				1: begin
					fill_next = 8'h00;
					send_idle_pct = 0;
					recv_idle_pct = 35;
				end
				2: begin
					fill_next = ATTR_W'($urandom);
					send_idle_pct = 40;
					recv_idle_pct = 0;
				end
				3: begin
					fill_next = ATTR_W'($urandom);
					send_idle_pct = 20;
					recv_idle_pct = 20;
				end
				default: begin
					fill_next = ATTR_W'($urandom);
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			write_fill(fill_next);
			send_item(OP_CLEAR, CHAR_W'($urandom), POS_W'($urandom), 1'b0, '0);
			// back the engine up while the sender keeps offering
			if (ph == 1)
				hold_req = 1'b1;
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target)
				random_sequence();
		end

		// drain
		@(negedge clk);
		push <= 1'b0;
		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (fail_count == 0)
			$display("[text_console_cursor_scroll] OK");
		else
			$display("[text_console_cursor_scroll] ERROR");
		$finish;
	end

endmodule

FILE: sim.f
rtl/tccs_pkg.sv
rtl/tccs_front.sv
rtl/tccs_resq.sv
rtl/tccs_engine.sv
rtl/text_console_cursor_scroll.sv
verif/tb_text_console_cursor_scroll.sv
